FILE: rtl/magnetometer_filter_calibration_macros.svh
// assertion macros for the magnetometer filter and calibration block
`ifndef MAGNETOMETER_FILTER_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_FILTER_CALIBRATION_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define MFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFC_ASSERT_IMP(label, ante, cons, msg)
`define MFC_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/mfc_pkg.sv
package mfc_pkg;

    // axis positions in the per-axis arrays
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // calibration phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_Z    = 2'd1;
    localparam logic [1:0] PH_X    = 2'd2;
    localparam logic [1:0] PH_Y    = 2'd3;

    // register indexes (paddr[2])
    localparam logic [0:0] REG_ACC_THR   = 1'b0;
    localparam logic [0:0] REG_GYRO_GAIN = 1'b1;

    localparam logic [14:0] ACC_THR_RST   = 15'd5000;
    localparam logic [15:0] GYRO_GAIN_RST = 16'd2048;

    // ceil(2^35 / 10): exact divide by ten for any 32 bit magnitude
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    // 360 degrees in Q24
    localparam logic signed [47:0] FULL_TURN = 48'sd6039797760;

    localparam logic signed [15:0] LIMIT_SMALL = 16'sd20;

    // accepted input beat
    typedef struct packed {
        logic [2:0][15:0] gyro;
        logic [2:0][15:0] acc;
        logic             start_cal;
        logic [2:0][15:0] raw;
    } mfc_in_t;

    // filter stage to calibration stage
    typedef struct packed {
        logic [2:0][32:0] turn_step;
        logic [2:0]       vert;
        logic             start_cal;
        logic [2:0][15:0] val;
    } mfc_mid_t;

    // result beat
    typedef struct packed {
        logic             save_request;
        logic [1:0]       cal_phase;
        logic             mag_valid;
        logic [2:0][16:0] mag;
    } mfc_out_t;

endpackage

FILE: rtl/magnetometer_filter_calibration.sv
// channel   | dir | beat width          | contents
// s_axis    | in  | tdata 152           | raw xyz, start_cal, acc xyz, gyro xyz
// m_axis    | out | tdata 56, tuser 1   | offset-corrected xyz, phase, save; valid
// apb       | in  | 32 bit, paddr 3     | acc_threshold at 0, gyro_step_gain at 4
//
// one beat per cycle while m_tready is high; a result reaches m_tdata through
// the input register, the filter stage and the calibration stage
// the filter stage divides by ten with a reciprocal multiply per axis
// reset clears filter, limits and angles at once; no clearing pass is needed
// m_tready low backs the stages up; s_tready drops only when all three are full
`include "magnetometer_filter_calibration_macros.svh"

module magnetometer_filter_calibration
    import mfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z, [48] start_cal,
    // [64:49] acc_x, [80:65] acc_y, [96:81] acc_z,
    // [112:97] gyro_x, [128:113] gyro_y, [144:129] gyro_z, rest zero
    input  logic [151:0] s_tdata,
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    // [16:0] mag_x, [33:17] mag_y, [50:34] mag_z, [52:51] cal_phase,
    // [53] save_request, rest zero
    output logic [55:0]  m_tdata,
    // [0] mag_valid
    output logic [0:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic        in_valid_reg;
    mfc_in_t     in_item_reg;
    logic [14:0] acc_thr_reg;
    logic [15:0] gyro_gain_reg;

    mfc_in_t     in_next;
    logic        filt_ready;
    logic        mid_valid;
    logic        mid_ready;
    mfc_mid_t    mid_item;
    mfc_out_t    out_item;
    logic        cfg_write;

    // input beat unpacking
    always_comb
    begin
        in_next.raw[AX_X]  = s_tdata[15:0];
        in_next.raw[AX_Y]  = s_tdata[31:16];
        in_next.raw[AX_Z]  = s_tdata[47:32];
        in_next.start_cal  = s_tdata[48];
        in_next.acc[AX_X]  = s_tdata[64:49];
        in_next.acc[AX_Y]  = s_tdata[80:65];
        in_next.acc[AX_Z]  = s_tdata[96:81];
        in_next.gyro[AX_X] = s_tdata[112:97];
        in_next.gyro[AX_Y] = s_tdata[128:113];
        in_next.gyro[AX_Z] = s_tdata[144:129];
    end

    assign s_tready = !in_valid_reg || filt_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_next;
    end

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_thr_reg   <= ACC_THR_RST;
            gyro_gain_reg <= GYRO_GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2:2])
                REG_ACC_THR:   acc_thr_reg   <= pwdata[14:0];
                REG_GYRO_GAIN: gyro_gain_reg <= pwdata[15:0];
                default:       acc_thr_reg   <= acc_thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            REG_ACC_THR:   prdata = {17'b0, acc_thr_reg};
            REG_GYRO_GAIN: prdata = {16'b0, gyro_gain_reg};
            default:       prdata = '0;
        endcase
    end

    mfc_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (filt_ready),
        .in_item   (in_item_reg),
        .acc_thr   (acc_thr_reg),
        .gyro_gain (gyro_gain_reg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item)
    );

    mfc_cal u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // result beat packing
    assign m_tdata = {2'b00, out_item.save_request, out_item.cal_phase,
                      out_item.mag[AX_Z], out_item.mag[AX_Y], out_item.mag[AX_X]};
    assign m_tuser = out_item.mag_valid;

    // input stalls only with every stage full and the output held
    `MFC_ASSERT_IMP(a_stall_full, !s_tready, in_valid_reg && mid_valid && m_tvalid && !m_tready, "input stalled with a free stage")

    // a save beat always reports the idle phase
    `MFC_ASSERT_IMP(a_save_idle, m_tvalid && m_tdata[53], m_tdata[52:51] == PH_IDLE, "save beat with phase not idle")

    // gain write lands in the register
    `MFC_ASSERT_NXT(a_gain_write, cfg_write && (paddr[2:2] == REG_GYRO_GAIN), gyro_gain_reg == $past(pwdata[15:0]), "gain write lost")

endmodule

FILE: rtl/mfc_filter.sv
module mfc_filter
    import mfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mfc_in_t       in_item,
    input  logic [14:0]   acc_thr,
    input  logic [15:0]   gyro_gain,
    output logic          mid_valid,
    input  logic          mid_ready,
    output mfc_mid_t      mid_item
);

    logic signed [31:0] acc_reg [3];
    logic signed [28:0] quo_reg [3];
    logic               mid_valid_reg;
    mfc_mid_t           mid_reg;

    logic signed [31:0] acc_next [3];
    logic signed [28:0] quo_next [3];
    logic [31:0]        acc_mag  [3];
    logic [63:0]        prod     [3];
    logic [27:0]        quo_mag  [3];
    logic [15:0]        val_sat  [3];
    logic [16:0]        acc_abs  [3];
    mfc_mid_t           mid_next;
    logic               fire;

    assign in_ready  = !mid_valid_reg || mid_ready;
    assign fire      = in_valid && in_ready;
    assign mid_valid = mid_valid_reg;
    assign mid_item  = mid_reg;

    // decaying filter: acc - acc/10 + sample, then divide by ten again
    always_comb
    begin
        mid_next = '0;
        mid_next.start_cal = in_item.start_cal;
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = acc_reg[k] - 32'(quo_reg[k])
                          + 32'($signed(in_item.raw[k]));
            acc_mag[k]  = acc_next[k][31] ? 32'(-acc_next[k]) : acc_next[k];
            prod[k]     = acc_mag[k] * RECIP_TEN;
            quo_mag[k]  = prod[k][62:35];
            quo_next[k] = acc_next[k][31] ? -$signed({1'b0, quo_mag[k]})
                                          : $signed({1'b0, quo_mag[k]});
            // saturate to 16 bits
            if (quo_next[k] > 29'sd32767)
                val_sat[k] = 16'h7FFF;
            else if (quo_next[k] < -29'sd32768)
                val_sat[k] = 16'h8000;
            else
                val_sat[k] = quo_next[k][15:0];
            mid_next.val[k] = val_sat[k];

            // accelerometer axis vertical test and gyro angle step
            acc_abs[k] = in_item.acc[k][15] ? 17'(-$signed({1'b1, in_item.acc[k]}))
                                            : {1'b0, in_item.acc[k]};
            mid_next.vert[k]      = acc_abs[k] > {2'b00, acc_thr};
            mid_next.turn_step[k] = 33'($signed(in_item.gyro[k])
                                        * $signed({1'b0, gyro_gain}));
        end
    end

    // filter state and stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                acc_reg[k] <= '0;
                quo_reg[k] <= '0;
            end
        end
        else
        begin
            if (in_ready)
                mid_valid_reg <= in_valid;
            if (fire)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc_reg[k] <= acc_next[k];
                    quo_reg[k] <= quo_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            mid_reg <= mid_next;
    end

endmodule

FILE: rtl/mfc_cal.sv
module mfc_cal
    import mfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mid_valid,
    output logic     mid_ready,
    input  mfc_mid_t mid_item,
    output logic     out_valid,
    input  logic     out_ready,
    output mfc_out_t out_item
);

    logic [15:0]        min_reg [3];
    logic [15:0]        max_reg [3];
    logic signed [47:0] ang_reg [3];
    logic [1:0]         phase_reg;
    logic               valid_flag_reg;
    logic               check_reg;
    logic               clear_reg;
    logic               out_valid_reg;
    mfc_out_t           out_reg;

    logic [15:0]        min_next [3];
    logic [15:0]        max_next [3];
    logic signed [47:0] ang_next [3];
    logic signed [47:0] ang_sum  [3];
    logic [2:0]         over;
    logic [1:0]         phase_next;
    logic               valid_flag_next;
    logic               check_next;
    logic               clear_next;
    logic               active;
    logic               clr_now;
    logic               chk;
    logic               save;
    logic [5:0]         near_zero;
    logic signed [16:0] lim_sum  [3];
    logic signed [16:0] mid_pt   [3];
    mfc_out_t           out_next;
    logic               fire;

    assign mid_ready = !out_valid_reg || out_ready;
    assign fire      = mid_valid && mid_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // calibration step: limits, turn detection, self-check, offset correction
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_next == PH_IDLE && mid_item.start_cal)
            phase_next = PH_Z;
        active          = (phase_next != PH_IDLE);
        clr_now         = active && clear_reg;
        valid_flag_next = active ? 1'b1 : valid_flag_reg;
        clear_next      = clr_now ? 1'b0 : clear_reg;
        save            = 1'b0;

        // limits and angles, cleared on the first step of a run
        for (int k = 0; k < 3; k++)
        begin
            min_next[k] = clr_now ? 16'h0000 : min_reg[k];
            max_next[k] = clr_now ? 16'h0000 : max_reg[k];
            ang_next[k] = clr_now ? 48'sd0 : ang_reg[k];
            ang_sum[k]  = ang_next[k] + 48'($signed(mid_item.turn_step[k]));
            over[k]     = (ang_sum[k] > FULL_TURN) || (ang_sum[k] < -FULL_TURN);
            if (active)
            begin
                if ($signed(min_next[k]) > $signed(mid_item.val[k]))
                    min_next[k] = mid_item.val[k];
                else if ($signed(max_next[k]) < $signed(mid_item.val[k]))
                    max_next[k] = mid_item.val[k];
            end
        end

        // phases may cascade within one beat
        if (phase_next == PH_Z && mid_item.vert[AX_Z])
        begin
            ang_next[AX_Z] = ang_sum[AX_Z];
            if (over[AX_Z])
                phase_next = PH_X;
        end
        if (phase_next == PH_X && mid_item.vert[AX_X])
        begin
            ang_next[AX_X] = ang_sum[AX_X];
            if (over[AX_X])
                phase_next = PH_Y;
        end
        if (phase_next == PH_Y && mid_item.vert[AX_Y])
        begin
            ang_next[AX_Y] = ang_sum[AX_Y];
            if (over[AX_Y])
            begin
                phase_next      = PH_IDLE;
                clear_next      = 1'b1;
                valid_flag_next = 1'b1;
                save            = 1'b1;
            end
        end

        // self-check: two or more near-zero limits mean unusable
        chk = check_reg || active;
        for (int k = 0; k < 3; k++)
        begin
            near_zero[k]     = ($signed(min_next[k]) < LIMIT_SMALL)
                               && ($signed(min_next[k]) > -LIMIT_SMALL);
            near_zero[k + 3] = ($signed(max_next[k]) < LIMIT_SMALL)
                               && ($signed(max_next[k]) > -LIMIT_SMALL);
        end
        check_next = chk ? 1'b0 : check_reg;
        if (chk && ($countones(near_zero) >= 2))
            valid_flag_next = 1'b0;

        // filtered value minus midpoint of limits, midpoint truncated toward zero
        for (int k = 0; k < 3; k++)
        begin
            lim_sum[k] = $signed({min_next[k][15], min_next[k]})
                         + $signed({max_next[k][15], max_next[k]});
            mid_pt[k]  = (lim_sum[k] + $signed({16'b0, lim_sum[k][16]})) >>> 1;
            out_next.mag[k] = 17'($signed({mid_item.val[k][15], mid_item.val[k]})
                                  - mid_pt[k]);
        end
        out_next.mag_valid    = valid_flag_next;
        out_next.cal_phase    = phase_next;
        out_next.save_request = save;
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            valid_flag_reg <= 1'b0;
            check_reg      <= 1'b1;
            clear_reg      <= 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                min_reg[k] <= '0;
                max_reg[k] <= '0;
                ang_reg[k] <= '0;
            end
        end
        else
        begin
            if (mid_ready)
                out_valid_reg <= mid_valid;
            if (fire)
            begin
                phase_reg      <= phase_next;
                valid_flag_reg <= valid_flag_next;
                check_reg      <= check_next;
                clear_reg      <= clear_next;
                for (int k = 0; k < 3; k++)
                begin
                    min_reg[k] <= min_next[k];
                    max_reg[k] <= max_next[k];
                    ang_reg[k] <= ang_next[k];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

endmodule
